// ----- hdl/smp_pkg.sv -----
// ----------------------------------------------------------------------------
// smp_pkg
// Shared widths, constants and types of the square matrix power block.
// ----------------------------------------------------------------------------
package smp_pkg;

    // Field widths fixed by the item format
    localparam int DATA_W    = 32;
    localparam int INDEX_W   = 3;
    localparam int ORDER_W   = 4;
    localparam int FRAC_W    = 16;
    localparam int PROD_W    = 2 * DATA_W;
    // Eight full-precision products summed without overflow
    localparam int SUM_W     = PROD_W + 3;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 40;

    // One in Q16.16
    localparam logic signed [DATA_W-1:0] Q_ONE = 32'sh0001_0000;

    // Control travelling with each operand pair into the MAC
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } mac_ctl_t;

endpackage

// ----- hdl/smp_ram.sv -----
// ----------------------------------------------------------------------------
// smp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module smp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hdl/smp_mac.sv -----
// ----------------------------------------------------------------------------
// smp_mac
// Pipelined signed multiply-accumulate with Q16.16 rescale and saturation.
// ----------------------------------------------------------------------------
module smp_mac #(
    parameter int TAG_W = 6
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  smp_pkg::mac_ctl_t                ctl,
    input  logic [TAG_W-1:0]                 tag,
    input  logic signed [smp_pkg::DATA_W-1:0] op_a,
    input  logic signed [smp_pkg::DATA_W-1:0] op_b,
    output logic                             done,
    output logic [TAG_W-1:0]                 done_tag,
    output logic signed [smp_pkg::DATA_W-1:0] result
);
    import smp_pkg::*;

    localparam int TOP_LSB = DATA_W + FRAC_W - 1;

    mac_ctl_t                 ctl1_reg;
    logic [TAG_W-1:0]         tag1_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic                     done_reg;
    logic [TAG_W-1:0]         tag2_reg;
    logic [SUM_W-1:TOP_LSB]   top_bits;

    // Control pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl1_reg <= '0;
            done_reg <= 1'b0;
        end else begin
            ctl1_reg <= ctl;
            done_reg <= ctl1_reg.valid && ctl1_reg.last;
        end
    end

    // Multiply, then accumulate at full precision
    always_ff @(posedge aclk) begin
        tag1_reg <= tag;
        prod_reg <= op_a * op_b;
        if (ctl1_reg.valid) begin
            sum_reg  <= (ctl1_reg.first ? SUM_W'(0) : sum_reg) + SUM_W'(prod_reg);
            tag2_reg <= tag1_reg;
        end
    end

    // Shift right by the fraction width and clamp to 32 bits
    assign top_bits = sum_reg[SUM_W-1:TOP_LSB];

    always_comb begin
        if ((&top_bits) || !(|top_bits)) begin
            result = sum_reg[TOP_LSB:FRAC_W];
        end else if (sum_reg[SUM_W-1]) begin
            result = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            result = {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

    assign done     = done_reg;
    assign done_tag = tag2_reg;

endmodule

// ----- hdl/square_matrix_power_top.sv -----
// ----------------------------------------------------------------------------
// square_matrix_power_top
// Raises a stored square Q16.16 matrix to an integer power.
// ----------------------------------------------------------------------------
// A load word (tuser 0) writes one base element. A compute word (tuser 1)
// starts from identity and multiplies by the base exponent times, then
// streams the n*n elements in row-major order with tlast on the final one.
// All products go through one shared multiply-accumulate unit at one
// product per cycle, so each multiply pass issues n*n*n products and then
// waits for the unit to drain; each result word then waits out any output
// stall, and is read through the single read port of the working matrix
// RAM. The input is not ready from the compute word until its last result
// word has gone, and the order register takes a write only while the block
// is idle. Working matrices ping-pong between two banks of one RAM, so no
// copy pass is needed.
module square_matrix_power_top #(
    parameter int MAX_ORDER     = 8,
    parameter int EXPONENT_BITS = 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // tdata: row_index[2:0], col_index[5:3], element_value[37:6], exponent[45:38]
    input  logic [smp_pkg::S_TDATA_W-1:0]    s_tdata,
    // tuser: command[0]
    input  logic [0:0]                       s_tuser,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // tdata: result_value[31:0], result_row[34:32], result_col[37:35]
    output logic [smp_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                             m_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [smp_pkg::ORDER_W-1:0]      cfg_wdata,
    input  logic                             cfg_wvalid,
    output logic                             cfg_wready
);
    import smp_pkg::*;

    localparam int CELLS   = MAX_ORDER * MAX_ORDER;
    localparam int ADDR_W  = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int MAT_D   = 2 * CELLS;
    localparam int MAT_AW  = $clog2(MAT_D);
    localparam int EXP_W   = (EXPONENT_BITS < 8) ? EXPONENT_BITS : 8;

    localparam logic       CMD_LOAD   = 1'b0;
    localparam logic       CMD_POWER  = 1'b1;
    localparam logic [1:0] DRAIN_LAST = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DRAIN,
        ST_OUT_RD,
        ST_OUT_LD,
        ST_OUT_SEND
    } state_t;

    state_t                    state_reg;
    logic [ORDER_W-1:0]        size_reg;
    logic [EXP_W-1:0]          rem_reg;
    logic [INDEX_W-1:0]        r_reg;
    logic [INDEX_W-1:0]        c_reg;
    logic [INDEX_W-1:0]        k_reg;
    logic                      bank_reg;
    logic                      ident_reg;
    logic [1:0]                drain_reg;
    mac_ctl_t                  iss_ctl_reg;
    logic [ADDR_W-1:0]         iss_tag_reg;
    logic signed [DATA_W-1:0]  ident_val_reg;
    logic                      m_tvalid_reg;
    logic signed [DATA_W-1:0]  m_data_reg;
    logic [INDEX_W-1:0]        m_row_reg;
    logic [INDEX_W-1:0]        m_col_reg;
    logic                      m_last_reg;

    logic [INDEX_W-1:0]        s_row;
    logic [INDEX_W-1:0]        s_col;
    logic signed [DATA_W-1:0]  s_value;
    logic [7:0]                s_exp;
    logic                      s_accept;
    logic                      cfg_accept;
    logic [ORDER_W-1:0]        n_eff;
    logic [ORDER_W-1:0]        n_last;
    logic                      r_end;
    logic                      c_end;
    logic                      k_end;
    logic                      base_we;
    logic [ADDR_W-1:0]         base_raddr;
    logic [DATA_W-1:0]         base_rdata;
    logic [MAT_AW-1:0]         mat_raddr;
    logic [MAT_AW-1:0]         mat_waddr;
    logic [DATA_W-1:0]         mat_rdata;
    logic signed [DATA_W-1:0]  op_a;
    logic                      mac_done;
    logic [ADDR_W-1:0]         mac_tag;
    logic signed [DATA_W-1:0]  mac_result;

    // Entry of a matrix element within one bank
    function automatic logic [ADDR_W-1:0] cell_addr(input logic [INDEX_W-1:0] row,
                                                    input logic [INDEX_W-1:0] col);
        cell_addr = ADDR_W'(32'(row) * MAX_ORDER + 32'(col));
    endfunction

    // Entry within the two-bank working RAM
    function automatic logic [MAT_AW-1:0] mat_addr(input logic bank,
                                                   input logic [ADDR_W-1:0] addr);
        mat_addr = MAT_AW'(32'(bank) * CELLS + 32'(addr));
    endfunction

    // Unpack the input word
    assign s_row    = s_tdata[2:0];
    assign s_col    = s_tdata[5:3];
    assign s_value  = s_tdata[37:6];
    assign s_exp    = s_tdata[45:38];
    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;

    // Hold off order writes while a power is being worked out
    assign cfg_wready = (state_reg == ST_IDLE);
    assign cfg_accept = cfg_wvalid && cfg_wready;

    // Clamp the order in use
    always_comb begin
        if (size_reg == '0) begin
            n_eff = ORDER_W'(1);
        end else if (32'(size_reg) > MAX_ORDER) begin
            n_eff = ORDER_W'(MAX_ORDER);
        end else begin
            n_eff = size_reg;
        end
    end

    assign n_last = n_eff - ORDER_W'(1);
    assign r_end  = ({1'b0, r_reg} == n_last);
    assign c_end  = ({1'b0, c_reg} == n_last);
    assign k_end  = ({1'b0, k_reg} == n_last);

    // Base store: written by load words, read by column during a pass
    assign base_we    = s_accept && (s_tuser[0] == CMD_LOAD) &&
                        (32'(s_row) < MAX_ORDER) && (32'(s_col) < MAX_ORDER);
    assign base_raddr = cell_addr(k_reg, c_reg);

    smp_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CELLS),
        .AW    (ADDR_W)
    ) u_base_ram (
        .aclk  (aclk),
        .we    (base_we),
        .waddr (cell_addr(s_row, s_col)),
        .wdata (s_value),
        .raddr (base_raddr),
        .rdata (base_rdata)
    );

    // Working store: read the current bank, write products to the other
    assign mat_raddr = (state_reg == ST_MUL) ? mat_addr(bank_reg, cell_addr(r_reg, k_reg))
                                             : mat_addr(bank_reg, cell_addr(r_reg, c_reg));
    assign mat_waddr = mat_addr(~bank_reg, mac_tag);

    smp_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAT_D),
        .AW    (MAT_AW)
    ) u_mat_ram (
        .aclk  (aclk),
        .we    (mac_done),
        .waddr (mat_waddr),
        .wdata (mac_result),
        .raddr (mat_raddr),
        .rdata (mat_rdata)
    );

    // Identity stands in for the accumulator on the first pass
    assign op_a = ident_reg ? ident_val_reg : mat_rdata;

    smp_mac #(
        .TAG_W (ADDR_W)
    ) u_mac (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (iss_ctl_reg),
        .tag      (iss_tag_reg),
        .op_a     (op_a),
        .op_b     (base_rdata),
        .done     (mac_done),
        .done_tag (mac_tag),
        .result   (mac_result)
    );

    // Sequencer and output word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            size_reg     <= ORDER_W'(8);
            rem_reg      <= '0;
            r_reg        <= '0;
            c_reg        <= '0;
            k_reg        <= '0;
            bank_reg     <= 1'b0;
            ident_reg    <= 1'b0;
            drain_reg    <= '0;
            iss_ctl_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_accept) begin
                size_reg <= cfg_wdata;
            end
            // Issue control: valid only while a multiply pass runs
            iss_ctl_reg <= mac_ctl_t'({(state_reg == ST_MUL), (k_reg == '0), k_end});
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_accept && (s_tuser[0] == CMD_POWER)) begin
                        rem_reg   <= s_exp[EXP_W-1:0];
                        ident_reg <= 1'b1;
                        r_reg     <= '0;
                        c_reg     <= '0;
                        k_reg     <= '0;
                        state_reg <= (s_exp[EXP_W-1:0] == '0) ? ST_OUT_RD : ST_MUL;
                    end
                end
                ST_MUL: begin
                    // Issue one operand pair and step k, then c, then r
                    iss_tag_reg   <= cell_addr(r_reg, c_reg);
                    ident_val_reg <= (r_reg == k_reg) ? Q_ONE : '0;
                    if (!k_end) begin
                        k_reg <= k_reg + INDEX_W'(1);
                    end else begin
                        k_reg <= '0;
                        if (!c_end) begin
                            c_reg <= c_reg + INDEX_W'(1);
                        end else begin
                            c_reg <= '0;
                            if (!r_end) begin
                                r_reg <= r_reg + INDEX_W'(1);
                            end else begin
                                r_reg     <= '0;
                                drain_reg <= '0;
                                state_reg <= ST_DRAIN;
                            end
                        end
                    end
                end
                ST_DRAIN: begin
                    // Wait for the last product to land, then swap banks
                    drain_reg <= drain_reg + 2'd1;
                    if (drain_reg == DRAIN_LAST) begin
                        bank_reg  <= ~bank_reg;
                        ident_reg <= 1'b0;
                        rem_reg   <= rem_reg - EXP_W'(1);
                        state_reg <= (rem_reg == EXP_W'(1)) ? ST_OUT_RD : ST_MUL;
                    end
                end
                ST_OUT_RD: begin
                    ident_val_reg <= (r_reg == c_reg) ? Q_ONE : '0;
                    state_reg     <= ST_OUT_LD;
                end
                ST_OUT_LD: begin
                    m_data_reg   <= ident_reg ? ident_val_reg : mat_rdata;
                    m_row_reg    <= r_reg;
                    m_col_reg    <= c_reg;
                    m_last_reg   <= r_end && c_end;
                    m_tvalid_reg <= 1'b1;
                    state_reg    <= ST_OUT_SEND;
                end
                ST_OUT_SEND: begin
                    // Hold the word until taken, then advance row-major
                    if (m_tready) begin
                        m_tvalid_reg <= 1'b0;
                        if (m_last_reg) begin
                            r_reg     <= '0;
                            c_reg     <= '0;
                            state_reg <= ST_IDLE;
                        end else begin
                            if (c_end) begin
                                c_reg <= '0;
                                r_reg <= r_reg + INDEX_W'(1);
                            end else begin
                                c_reg <= c_reg + INDEX_W'(1);
                            end
                            state_reg <= ST_OUT_RD;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Pack the result word
    assign m_tdata  = {2'b00, m_col_reg, m_row_reg, m_data_reg};
    assign m_tlast  = m_last_reg;
    assign m_tvalid = m_tvalid_reg;

    // A pending result word keeps the input closed
    a_out_blocks_in: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input ready while a result word is pending");

    // A compute word closes the input on the next cycle
    a_compute_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser[0] == CMD_POWER)) |=> !s_tready)
        else $error("input still ready after a compute word");

    // Products land only while a multiply pass is running or draining
    a_write_in_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        mac_done |-> (state_reg == ST_MUL || state_reg == ST_DRAIN))
        else $error("product written outside a multiply pass");

endmodule
